FILE: rtl/core/toroidal_life_grid_core_assert.svh
// Assertion macros for the toroidal Life grid core.
// Used by the top level; compiles to nothing when SYNTHESIS is defined.
`ifndef TOROIDAL_LIFE_GRID_CORE_ASSERT_SVH
`define TOROIDAL_LIFE_GRID_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define TLG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle
`define TLG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLG_ASSERT(lbl, prop, msg)
`define TLG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/tlg_pkg.sv
// Shared types and constants of the toroidal Life grid core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tlg_pkg;

  // Request field layout on the input stream
  localparam int unsigned FuncW    = 2;
  localparam int unsigned RowW     = 3;
  localparam int unsigned ColW     = 3;
  localparam int unsigned InDataW  = 8;
  // Result field layout on the output stream
  localparam int unsigned PopW     = 6;
  localparam int unsigned OutDataW = 8;
  localparam logic [PopW-1:0] PopMax = 6'd63;

  // Life rule: survive on two or three neighbours, birth on three
  localparam logic [3:0] LifeSurviveLo = 4'd2;
  localparam logic [3:0] LifeBirth     = 4'd3;

  // Request function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_ISSUE,
    ST_LOOK,
    ST_RESP
  } state_e;

endpackage

FILE: rtl/core/toroidal_life_grid_core.sv
// Toroidal Life grid core: step, seed or query a wrapping grid of cells.
// Sequence: a set or query request passes ISSUE, LOOK and RESP to its registered result;
// a generation step first sweeps GEN, one row per cycle through the single memory read port.
// Flow: one request at a time; the next is taken the cycle after the result is
// registered, so output stalls in RESP also hold off the next request.
// Reset (rst_ni low, asynchronous): all cells dead, population zero, no result pending.
`timescale 1ns / 1ps
`include "toroidal_life_grid_core_assert.svh"
module toroidal_life_grid_core #(
  parameter int unsigned GRID_ROWS = 6,
  parameter int unsigned GRID_COLS = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] func, [4:2] row, [7:5] col
  input  logic [tlg_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] cell_alive, [6:1] population, [7] zero
  output logic [tlg_pkg::OutDataW-1:0]  m_axis_tdata
);
  import tlg_pkg::*;

  localparam int unsigned RW   = $clog2(GRID_ROWS);
  localparam int unsigned CW   = $clog2(GRID_COLS);
  localparam int unsigned KW   = $clog2(GRID_ROWS + 3);
  localparam int unsigned PW   = $clog2(GRID_ROWS * GRID_COLS + 1);
  localparam int unsigned CNTW = $clog2(GRID_COLS + 1);

  state_e             state_q, state_d;
  logic [FuncW-1:0]   func_q;
  logic [RowW-1:0]    row_q;
  logic [ColW-1:0]    col_q;
  logic [KW-1:0]      k_q, k_d;
  logic [GRID_COLS-1:0] top_q, mid_q, row0_q;
  logic [PW-1:0]      pop_q, pop_d;
  logic               alive_q, alive_d;
  logic               out_vld_q;
  logic [OutDataW-1:0] out_data_q;

  logic               in_req;
  logic               out_free;
  logic               rd_en, wr_en;
  logic [RW-1:0]      rd_addr, wr_addr;
  logic [GRID_COLS-1:0] rd_data, wr_data, bot, nxt;
  logic [CNTW-1:0]    cnt_old, cnt_new;
  logic [KW-1:0]      k_m1, k_m3;
  logic [RW+RowW-1:0] row_ext;
  logic [CW+ColW-1:0] col_ext;
  logic               addr_in;
  logic [RW-1:0]      row_idx;
  logic [CW-1:0]      col_idx;
  logic               cell_bit;
  logic               shift_en, row0_en, load_out;
  logic [PW+PopW-1:0] pop_ext;
  logic [PopW-1:0]    pop_sat;

  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  // Decode the addressed cell, clamped to row and column zero when outside the grid
  assign row_ext = {RW'(0), row_q};
  assign col_ext = {CW'(0), col_q};
  assign addr_in = (row_ext < (RW + RowW)'(GRID_ROWS)) && (col_ext < (CW + ColW)'(GRID_COLS));
  assign row_idx = addr_in ? row_ext[RW-1:0] : '0;
  assign col_idx = addr_in ? col_ext[CW-1:0] : '0;
  assign cell_bit = rd_data[col_idx];

  // Sweep counter offsets for read and write addresses
  assign k_m1 = k_q - KW'(1);
  assign k_m3 = k_q - KW'(3);
  assign bot  = (k_q == KW'(GRID_ROWS + 2)) ? row0_q : rd_data;

  tlg_row_mem #(
    .ROWS (GRID_ROWS),
    .COLS (GRID_COLS),
    .AW   (RW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  tlg_row_rule #(
    .COLS (GRID_COLS),
    .CNTW (CNTW)
  ) u_rule (
    .top_i     (top_q),
    .mid_i     (mid_q),
    .bot_i     (bot),
    .nxt_o     (nxt),
    .cnt_old_o (cnt_old),
    .cnt_new_o (cnt_new)
  );

  // Saturate the population for the result field
  assign pop_ext = {PopW'(0), pop_q};
  assign pop_sat = (pop_ext > (PW + PopW)'(PopMax)) ? PopMax : pop_ext[PopW-1:0];

  // Sequence a request: generation sweep, addressed read, modify, respond
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    pop_d    = pop_q;
    alive_d  = alive_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = nxt;
    shift_en = 1'b0;
    row0_en  = 1'b0;
    load_out = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_req) begin
          k_d     = '0;
          state_d = (s_axis_tdata[FuncW-1:0] == FUNC_STEP) ? ST_GEN : ST_ISSUE;
        end
      end
      ST_GEN: begin
        // Read the last row first, then rows from zero up
        if (k_q <= KW'(GRID_ROWS)) begin
          rd_en   = 1'b1;
          rd_addr = (k_q == '0) ? RW'(GRID_ROWS - 1) : k_m1[RW-1:0];
        end
        shift_en = (k_q >= KW'(1)) && (k_q <= KW'(GRID_ROWS + 1));
        row0_en  = (k_q == KW'(2));
        // Write each new row once its lower neighbour is in
        if (k_q >= KW'(3)) begin
          wr_en   = 1'b1;
          wr_addr = k_m3[RW-1:0];
          pop_d   = pop_q + PW'(cnt_new) - PW'(cnt_old);
        end
        k_d = k_q + KW'(1);
        if (k_q == KW'(GRID_ROWS + 2)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = row_idx;
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        alive_d = addr_in && cell_bit;
        if ((func_q == FUNC_SET) && addr_in) begin
          wr_en   = 1'b1;
          wr_addr = row_idx;
          wr_data = rd_data | (GRID_COLS'(1) << col_idx);
          alive_d = 1'b1;
          if (!cell_bit) begin
            pop_d = pop_q + PW'(1);
          end
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      pop_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pop_q   <= pop_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Capture the request, the row window and the result
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      func_q <= s_axis_tdata[FuncW-1:0];
      row_q  <= s_axis_tdata[FuncW +: RowW];
      col_q  <= s_axis_tdata[FuncW + RowW +: ColW];
    end
    if (shift_en) begin
      top_q <= mid_q;
      mid_q <= rd_data;
    end
    if (row0_en) begin
      row0_q <= rd_data;
    end
    alive_q <= alive_d;
    if (load_out) begin
      out_data_q <= {1'b0, pop_sat, alive_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `TLG_ASSERT(a_pop_bound, pop_q <= PW'(GRID_ROWS * GRID_COLS), "population above grid size")
  `TLG_ASSERT_NEXT(a_req_start, in_req, (state_q == ST_GEN) || (state_q == ST_ISSUE), "no start")
  `TLG_ASSERT(a_wr_phase, !wr_en || (state_q == ST_GEN) || (state_q == ST_LOOK), "stray write")
  `TLG_ASSERT(a_out_rise, !$rose(m_axis_tvalid) || ($past(state_q) == ST_RESP), "early result")

endmodule

FILE: rtl/core/tlg_row_mem.sv
// Row memory of the Life grid: one row of cells per entry, one read and one write port.
// Read data registered; per-row valid bits make unwritten rows read as all dead.
`timescale 1ns / 1ps
module tlg_row_mem #(
  parameter int unsigned ROWS = 6,
  parameter int unsigned COLS = 7,
  parameter int unsigned AW   = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output logic [COLS-1:0] rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  logic [COLS-1:0] wr_data_i
);
  import tlg_pkg::*;

  logic [COLS-1:0] mem_q [ROWS];
  logic [ROWS-1:0] vld_q;
  logic [COLS-1:0] rd_raw_q;
  logic            rd_vld_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Track rows written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_raw_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

endmodule

FILE: rtl/core/tlg_row_rule.sv
// Next-generation logic for one grid row from the rows above, at and below it.
// Wraps columns around; also counts live cells in the old and new row.
`timescale 1ns / 1ps
module tlg_row_rule #(
  parameter int unsigned COLS = 7,
  parameter int unsigned CNTW = 3
) (
  input  logic [COLS-1:0] top_i,
  input  logic [COLS-1:0] mid_i,
  input  logic [COLS-1:0] bot_i,
  output logic [COLS-1:0] nxt_o,
  output logic [CNTW-1:0] cnt_old_o,
  output logic [CNTW-1:0] cnt_new_o
);
  import tlg_pkg::*;

  // Apply the Life rule to every column in parallel
  for (genvar c = 0; c < COLS; c++) begin : g_cell
    localparam int unsigned Lc = (c + COLS - 1) % COLS;
    localparam int unsigned Rc = (c + 1) % COLS;
    logic [3:0] nbr;
    assign nbr = 4'(top_i[Lc]) + 4'(top_i[c]) + 4'(top_i[Rc])
               + 4'(mid_i[Lc]) + 4'(mid_i[Rc])
               + 4'(bot_i[Lc]) + 4'(bot_i[c]) + 4'(bot_i[Rc]);
    assign nxt_o[c] = mid_i[c] ? ((nbr == LifeSurviveLo) || (nbr == LifeBirth))
                               : (nbr == LifeBirth);
  end

  // Count live cells in the old and the new row
  always_comb begin
    cnt_old_o = '0;
    cnt_new_o = '0;
    for (int i = 0; i < COLS; i++) begin
      cnt_old_o = cnt_old_o + CNTW'(mid_i[i]);
      cnt_new_o = cnt_new_o + CNTW'(nxt_o[i]);
    end
  end

endmodule

FILE: tb/toroidal_life_grid_core_tb.sv
// Self-checking testbench for the toroidal Life grid core: seeds, steps and queries the grid.
// Depends on tlg_pkg and toroidal_life_grid_core; a scoreboard class predicts every result.
`timescale 1ns / 1ps
module toroidal_life_grid_core_tb;
  import tlg_pkg::*;

  localparam int unsigned Rows       = 6;
  localparam int unsigned Cols       = 7;
  localparam int unsigned RandItems  = 1650;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainWait  = 16;

  // Expected result, alive flag in the lowest bit
  typedef struct packed {
    logic            pad;
    logic [PopW-1:0] population;
    logic            alive;
  } life_result_t;

  // Grid predictor and store of pending cell reports
  class life_scoreboard;
    logic [Cols-1:0] cells [Rows];
    life_result_t    expected_q [$];
    int unsigned     errors;

    function new();
      foreach (cells[r]) cells[r] = '0;
      errors = 0;
    endfunction

    // Apply one accepted request to the grid and queue its report
    function void note_request(logic [InDataW-1:0] data);
      func_e           fn;
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
      bit              in_grid;
      logic [Cols-1:0] next_cells [Rows];
      int unsigned     nbrs;
      int unsigned     total;
      life_result_t    res;
      fn      = func_e'(data[1:0]);
      row     = data[4:2];
      col     = data[7:5];
      in_grid = (row < Rows) && (col < Cols);
      if (fn == FUNC_STEP) begin
        // Count the eight wrapped neighbours of every cell from the old grid
        for (int r = 0; r < Rows; r++) begin
          for (int c = 0; c < Cols; c++) begin
            nbrs = 0;
            for (int dr = 0; dr < 3; dr++) begin
              for (int dc = 0; dc < 3; dc++) begin
                if (!(dr == 1 && dc == 1)) begin
                  nbrs += cells[(r + Rows + dr - 1) % Rows][(c + Cols + dc - 1) % Cols];
                end
              end
            end
            if (cells[r][c]) begin
              next_cells[r][c] = (nbrs == LifeSurviveLo) || (nbrs == LifeBirth);
            end else begin
              next_cells[r][c] = (nbrs == LifeBirth);
            end
          end
        end
        cells = next_cells;
      end else if (fn == FUNC_SET && in_grid) begin
        cells[row][col] = 1'b1;
      end
      res = '0;
      if (in_grid) begin
        res.alive = cells[row][col];
      end
      total = 0;
      foreach (cells[r]) total += $countones(cells[r]);
      res.population = (total > PopMax) ? PopMax : total[PopW-1:0];
      expected_q.push_back(res);
    endfunction

    // Compare one delivered report against the oldest prediction
    function void check_result(logic [OutDataW-1:0] data);
      life_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h, nothing pending", $time, data);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (data[0] !== exp_res.alive) begin
        $display("%0t: cell_alive expected %0d actual %0d", $time, exp_res.alive, data[0]);
        errors++;
      end
      if (data[6:1] !== exp_res.population) begin
        $display("%0t: population expected %0d actual %0d", $time,
                 exp_res.population, data[6:1]);
        errors++;
      end
      if (data[7] !== exp_res.pad) begin
        $display("%0t: pad bit expected %0d actual %0d", $time, exp_res.pad, data[7]);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [1:0] func, [4:2] row, [7:5] col
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [0] cell_alive, [6:1] population, [7] zero
  logic [OutDataW-1:0] m_axis_tdata;

  life_scoreboard grid_sb;
  int unsigned    sent_cnt;
  int unsigned    rx_cycle;
  int unsigned    quiet_cycles;

  toroidal_life_grid_core #(
    .GRID_ROWS(Rows),
    .GRID_COLS(Cols)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Observe both handshakes with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) grid_sb.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) grid_sb.check_result(m_axis_tdata);
    end
  end

  // Offer one request, idling at random outside the steady stretch
  task automatic send_request(input func_e fn, input logic [RowW-1:0] row,
                              input logic [ColW-1:0] col);
    while (!(sent_cnt >= 700 && sent_cnt < 1000) && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {col, row, fn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Seed a small cluster around a random spot, then let it evolve
  task automatic run_pattern();
    int unsigned r0;
    int unsigned c0;
    r0 = $urandom_range(0, Rows - 1);
    c0 = $urandom_range(0, Cols - 1);
    repeat ($urandom_range(3, 6)) begin
      send_request(FUNC_SET, RowW'((r0 + $urandom_range(0, 2)) % Rows),
                   ColW'((c0 + $urandom_range(0, 2)) % Cols));
    end
    repeat ($urandom_range(1, 8)) begin
      send_request(FUNC_STEP, RowW'($urandom_range(0, Rows - 1)),
                   ColW'($urandom_range(0, Cols - 1)));
      if ($urandom_range(0, 1)) begin
        send_request(FUNC_QUERY, RowW'((r0 + $urandom_range(0, 2)) % Rows),
                     ColW'((c0 + $urandom_range(0, 2)) % Cols));
      end
    end
  endtask

  // Mix in unused codes, off-grid addresses and plain queries
  task automatic run_noise();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 2))
        0: begin
          send_request(FUNC_NOP, RowW'($urandom_range(0, 7)), ColW'($urandom_range(0, 7)));
        end
        1: begin
          if ($urandom_range(0, 1)) begin
            send_request(func_e'($urandom_range(0, 2)), RowW'($urandom_range(Rows, 7)),
                         ColW'($urandom_range(0, 7)));
          end else begin
            send_request(func_e'($urandom_range(0, 2)), RowW'($urandom_range(0, 7)), 3'd7);
          end
        end
        default: begin
          send_request(FUNC_QUERY, RowW'($urandom_range(0, Rows - 1)),
                       ColW'($urandom_range(0, Cols - 1)));
        end
      endcase
    end
  endtask

  // Receiver: random stalls, one long hold-off and one stretch always ready
  initial begin
    m_axis_tready = 1'b0;
    rx_cycle      = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle >= 3000 && rx_cycle < 3400) begin
        m_axis_tready <= 1'b0;
      end else if (rx_cycle >= 5000 && rx_cycle < 7000) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // Watchdog: stop when neither side moves for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    grid_sb       = new();
    sent_cnt      = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty grid, then the four corners, which form a still block through the wrap
    send_request(FUNC_QUERY, 3'd0, 3'd0);
    send_request(FUNC_SET,   3'd0, 3'd0);
    send_request(FUNC_SET,   3'd5, 3'd6);
    send_request(FUNC_SET,   3'd0, 3'd6);
    send_request(FUNC_SET,   3'd5, 3'd0);
    send_request(FUNC_STEP,  3'd0, 3'd0);
    send_request(FUNC_QUERY, 3'd5, 3'd6);
    // Off-grid addresses and the unused code change nothing
    send_request(FUNC_SET,   3'd6, 3'd3);
    send_request(FUNC_SET,   3'd7, 3'd7);
    send_request(FUNC_QUERY, 3'd2, 3'd7);
    send_request(FUNC_NOP,   3'd0, 3'd0);
    // Blinker in the middle, stepped twice
    send_request(FUNC_SET,   3'd2, 3'd2);
    send_request(FUNC_SET,   3'd2, 3'd3);
    send_request(FUNC_SET,   3'd2, 3'd4);
    send_request(FUNC_STEP,  3'd1, 3'd3);
    send_request(FUNC_STEP,  3'd2, 3'd3);
    send_request(FUNC_QUERY, 3'd1, 3'd3);
    // Step with an off-grid address still advances
    send_request(FUNC_STEP,  3'd7, 3'd0);
    send_request(FUNC_SET,   3'd0, 3'd0);
    send_request(FUNC_QUERY, 3'd3, 3'd5);
    // Extend the vertical blinker in column 3 across the top and bottom edge
    send_request(FUNC_SET,   3'd5, 3'd3);
    send_request(FUNC_SET,   3'd0, 3'd3);
    send_request(FUNC_SET,   3'd1, 3'd3);
    send_request(FUNC_STEP,  3'd0, 3'd2);
    send_request(FUNC_QUERY, 3'd0, 3'd4);

    // Random part: mostly evolving patterns, some noise
    while (sent_cnt < RandItems + 25) begin
      if ($urandom_range(0, 99) < 75) begin
        run_pattern();
      end else begin
        run_noise();
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding reports, then watch for strays
    while (grid_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (grid_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tlg_pkg.sv
rtl/core/tlg_row_mem.sv
rtl/core/tlg_row_rule.sv
rtl/core/toroidal_life_grid_core.sv
tb/toroidal_life_grid_core_tb.sv
